// ----- src/three_axis_hit_detector_macros.svh -----
// Assertion macros shared by the hit detector RTL.
`ifndef THREE_AXIS_HIT_DETECTOR_MACROS_SVH
`define THREE_AXIS_HIT_DETECTOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TAHD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TAHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tahd_pkg.sv -----
// Types and constants of the three-axis hit detector.
package tahd_pkg;

  localparam int NUM_AXES   = 3;
  localparam int SAMPLE_W   = 12;
  localparam int TRIG_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Number of beats averaged into the baseline after reset (1 to 128).
  localparam int CALIB_SAMPLES = 100;
  localparam int CAL_CNT_W     = $clog2(CALIB_SAMPLES + 1);
  localparam int SUM_W         = 19;

  // Exact floor division by CALIB_SAMPLES for any SUM_W-bit sum:
  // q = (sum * RECIP) >> RECIP_SHIFT with RECIP = ceil(2^RECIP_SHIFT / CALIB_SAMPLES).
  localparam int RECIP_SHIFT = SUM_W + $clog2(CALIB_SAMPLES);
  localparam longint RECIP_L =
    ((64'd1 << RECIP_SHIFT) + CALIB_SAMPLES - 1) / CALIB_SAMPLES;
  localparam int RECIP_W = RECIP_SHIFT + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;

  localparam logic [TRIG_W-1:0] TRIG_RESET = TRIG_W'(400);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIGGER_X = 2'd0,
    REG_TRIGGER_Y = 2'd1,
    REG_TRIGGER_Z = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_CALIB  = 2'd0,
    PH_DIVIDE = 2'd1,
    PH_RUN    = 2'd2
  } phase_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_x;
    logic [SAMPLE_W-1:0] sample_y;
    logic [SAMPLE_W-1:0] sample_z;
  } in_t;

  typedef struct packed {
    logic hit_x;
    logic hit_y;
    logic hit_z;
    logic calibrating;
  } out_t;

endpackage

// ----- src/three_axis_hit_detector.sv -----
// Three-axis hit detector with baseline calibration and per-axis hysteresis.
// After reset the first CALIB_SAMPLES input beats (100) are summed per axis and
// reported with calibrating set and no hits; the truncated mean of each sum then
// becomes that axis baseline and all axes are armed. From then on each sample
// is clamped to at least its baseline, and its distance above the baseline is
// checked: an armed axis whose distance exceeds its trigger reports a hit and
// disarms, and a disarmed axis re-arms once the distance drops below half the
// trigger. The block takes one beat per clock cycle unless the output
// stalls; an accepted beat passes the input register, then the result
// register. The other exception is the cycle right after the last
// calibration beat, when the baseline divide (a constant reciprocal multiply
// per axis) is registered and no beat moves forward; it happens once per reset.
// Triggers are written through the cfg port at any index 0 to 2; other indexes
// are ignored. There is no reset clearing pass.
`include "three_axis_hit_detector_macros.svh"

module three_axis_hit_detector
  import tahd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  // Input stage.
  logic                v1_r, v1_nxt;
  in_t                 smp_r, smp_nxt;
  // Result stage.
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;
  // Block state.
  phase_t              phase_r, phase_nxt;
  logic [CAL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_AXES-1:0] armed_r, armed_nxt;
  logic [TRIG_W-1:0]   trig_r   [NUM_AXES];
  logic [TRIG_W-1:0]   trig_nxt [NUM_AXES];
  logic [SAMPLE_W-1:0] base_r   [NUM_AXES];
  logic [SAMPLE_W-1:0] base_nxt [NUM_AXES];
  logic [SUM_W-1:0]    sum_r    [NUM_AXES];
  logic [SUM_W-1:0]    sum_nxt  [NUM_AXES];

  logic                adv;
  logic [SAMPLE_W-1:0] samp  [NUM_AXES];
  logic [SAMPLE_W-1:0] delta [NUM_AXES];
  logic [PROD_W-1:0]   prod  [NUM_AXES];
  logic [NUM_AXES-1:0] hit;

  assign samp[0] = smp_r.sample_x;
  assign samp[1] = smp_r.sample_y;
  assign samp[2] = smp_r.sample_z;

  // Per-axis distance above baseline and the baseline divide.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      delta[a] = (samp[a] < base_r[a]) ? '0 : (samp[a] - base_r[a]);
      prod[a]  = {{RECIP_W{1'b0}}, sum_r[a]} * {{SUM_W{1'b0}}, RECIP};
    end
  end

  // The input stage moves forward when the result register is free or being
  // drained, except while the baselines are being loaded.
  assign adv      = v1_r && (phase_r != PH_DIVIDE) && (!out_valid_r || out_ready);
  assign in_ready = !v1_r || adv;

  always_comb begin
    v1_nxt        = v1_r;
    smp_nxt       = smp_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    armed_nxt     = armed_r;
    hit           = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      trig_nxt[a] = trig_r[a];
      base_nxt[a] = base_r[a];
      sum_nxt[a]  = sum_r[a];
    end

    if (in_valid && in_ready) begin
      v1_nxt  = 1'b1;
      smp_nxt = in_data;
    end else if (adv) begin
      v1_nxt = 1'b0;
    end

    if (adv) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      unique case (phase_r)
        PH_CALIB: begin
          for (int a = 0; a < NUM_AXES; a++) begin
            sum_nxt[a] = sum_r[a] + SUM_W'(samp[a]);
          end
          cnt_nxt = cnt_r + CAL_CNT_W'(1);
          out_data_nxt.calibrating = 1'b1;
          if (cnt_nxt == CAL_CNT_W'(CALIB_SAMPLES)) begin
            phase_nxt = PH_DIVIDE;
          end
        end
        PH_RUN: begin
          for (int a = 0; a < NUM_AXES; a++) begin
            if (armed_r[a] && (delta[a] > trig_r[a])) begin
              hit[a]       = 1'b1;
              armed_nxt[a] = 1'b0;
            end else if (!armed_r[a] && (delta[a] < (trig_r[a] >> 1))) begin
              armed_nxt[a] = 1'b1;
            end
          end
          out_data_nxt.hit_x = hit[0];
          out_data_nxt.hit_y = hit[1];
          out_data_nxt.hit_z = hit[2];
        end
        default: begin
        end
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Load the baselines in the cycle after the last calibration beat.
    if (phase_r == PH_DIVIDE) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        base_nxt[a] = prod[a][RECIP_SHIFT +: SAMPLE_W];
      end
      armed_nxt = '1;
      phase_nxt = PH_RUN;
    end

    if (cfg_we) begin
      unique case (cfg_idx)
        REG_TRIGGER_X: trig_nxt[0] = cfg_wdata[TRIG_W-1:0];
        REG_TRIGGER_Y: trig_nxt[1] = cfg_wdata[TRIG_W-1:0];
        REG_TRIGGER_Z: trig_nxt[2] = cfg_wdata[TRIG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_CALIB;
      cnt_r       <= '0;
      armed_r     <= '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        trig_r[a] <= TRIG_RESET;
        base_r[a] <= '0;
        sum_r[a]  <= '0;
      end
    end else begin
      v1_r        <= v1_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      armed_r     <= armed_nxt;
      for (int a = 0; a < NUM_AXES; a++) begin
        trig_r[a] <= trig_nxt[a];
        base_r[a] <= base_nxt[a];
        sum_r[a]  <= sum_nxt[a];
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    smp_r      <= smp_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A calibration beat never carries a hit.
  `TAHD_ASSERT_NOW(a_no_hit_in_calib, clk, rst_n,
    out_valid_r && out_data_r.calibrating,
    !out_data_r.hit_x && !out_data_r.hit_y && !out_data_r.hit_z,
    "hit reported on a calibration beat")
  // The baseline load ends in the next cycle and nothing advances meanwhile.
  `TAHD_ASSERT_NEXT(a_divide_once, clk, rst_n,
    phase_r == PH_DIVIDE,
    phase_r == PH_RUN && armed_r == '1,
    "baseline load did not finish in one cycle")
  `TAHD_ASSERT_NOW(a_divide_stall, clk, rst_n,
    phase_r == PH_DIVIDE, !adv,
    "beat moved forward while baselines were loading")
  // A hit on x leaves the x axis disarmed.
  `TAHD_ASSERT_NEXT(a_hit_disarms, clk, rst_n,
    adv && hit[0], !armed_r[0],
    "x axis still armed after a hit")

endmodule

// ----- tb/three_axis_hit_detector_test.sv -----
// Self-checking testbench for the three-axis hit detector.
module three_axis_hit_detector_test;
  import tahd_pkg::*;

  // Clock period and the hard stop, placed far beyond the slowest legal run here.
  localparam int CLK_PERIOD     = 10;
  localparam int TIMEOUT_CYCLES = 300000;
  localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
  localparam int RANDOM_BEATS   = 100;

  // The cfg port is two bits wide, so index 3 exists on the wire but names
  // no register. The block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  three_axis_hit_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Our own copy of the detector state. It advances once per accepted input
  // beat, inside the driver, so it always matches what the block has seen.
  logic [TRIG_W-1:0]    trig_model [NUM_AXES] = '{TRIG_RESET, TRIG_RESET, TRIG_RESET};
  logic [SAMPLE_W-1:0]  baseline   [NUM_AXES] = '{default: '0};
  logic [SUM_W-1:0]     cal_sum    [NUM_AXES] = '{default: '0};
  logic [CAL_CNT_W-1:0] cal_seen = '0;
  logic [NUM_AXES-1:0]  armed    = '0;

  in_t  pending_items [$];
  out_t expected_hits [$];
  out_t oldest;
  int   errors     = 0;
  int   burst_left = 1;
  int   gap_left   = 0;
  logic [7:0] rx_tick = '0;

  // Works out the result beat for one sample triple and updates the state.
  // During calibration the samples only feed the sums; the beat that
  // completes calibration loads the baselines and arms every axis.
  function automatic out_t predict_hits(in_t item);
    logic [SAMPLE_W-1:0] smp [NUM_AXES];
    logic [SAMPLE_W-1:0] lvl;
    logic [SAMPLE_W-1:0] delta;
    logic [NUM_AXES-1:0] fired;
    out_t res;
    int a;
    smp[0] = item.sample_x;
    smp[1] = item.sample_y;
    smp[2] = item.sample_z;
    res = '0;
    fired = '0;
    if (cal_seen < CALIB_SAMPLES) begin
      for (a = 0; a < NUM_AXES; a++) begin
        cal_sum[a] = cal_sum[a] + SUM_W'(smp[a]);
      end
      cal_seen = cal_seen + 1'b1;
      if (cal_seen == CALIB_SAMPLES) begin
        for (a = 0; a < NUM_AXES; a++) begin
          baseline[a] = SAMPLE_W'(cal_sum[a] / CALIB_SAMPLES);
        end
        armed = '1;
      end
      res.calibrating = 1'b1;
      return res;
    end
    for (a = 0; a < NUM_AXES; a++) begin
      // A sample below the baseline counts as sitting right on it.
      lvl   = (smp[a] < baseline[a]) ? baseline[a] : smp[a];
      delta = lvl - baseline[a];
      if (armed[a] && delta > trig_model[a]) begin
        fired[a] = 1'b1;
        armed[a] = 1'b0;
      end else if (!armed[a] && delta < (trig_model[a] >> 1)) begin
        armed[a] = 1'b1;
      end
    end
    res.hit_x = fired[0];
    res.hit_y = fired[1];
    res.hit_z = fired[2];
    return res;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic logic [SAMPLE_W-1:0] clip_sample(int v);
    if (v < 0) begin
      return '0;
    end
    if (v > SAMPLE_MAX) begin
      return SAMPLE_W'(SAMPLE_MAX);
    end
    return SAMPLE_W'(v);
  endfunction

  // Random sample for one axis, weighted toward the interesting levels: right
  // at the trigger, right at the re-arm level, quiet, below the baseline, well
  // above the trigger, and now and then anywhere on the scale.
  function automatic logic [SAMPLE_W-1:0] pick_sample(int lvl, int thr);
    int v;
    case ($urandom_range(0, 9))
      0:       v = int'($urandom_range(0, SAMPLE_MAX));
      1:       v = int'($urandom_range(0, lvl));
      2, 3, 4: v = lvl + thr + int'($urandom_range(0, 4)) - 2;
      5, 6:    v = lvl + thr / 2 + int'($urandom_range(0, 2)) - 1;
      7, 8:    v = lvl + int'($urandom_range(0, thr / 4));
      default: v = lvl + thr + int'($urandom_range(0, SAMPLE_MAX));
    endcase
    return clip_sample(v);
  endfunction

  // Queues one beat whose samples sit at the given distances from the
  // baselines, clipped to the converter range.
  task automatic push_offsets(input int dx, input int dy, input int dz);
    in_t item;
    item.sample_x = clip_sample(int'(baseline[0]) + dx);
    item.sample_y = clip_sample(int'(baseline[1]) + dy);
    item.sample_z = clip_sample(int'(baseline[2]) + dz);
    pending_items.push_back(item);
  endtask

  task automatic push_random(input int count);
    in_t item;
    repeat (count) begin
      item.sample_x = pick_sample(int'(baseline[0]), int'(trig_model[0]));
      item.sample_y = pick_sample(int'(baseline[1]), int'(trig_model[1]));
      item.sample_z = pick_sample(int'(baseline[2]), int'(trig_model[2]));
      pending_items.push_back(item);
    end
  endtask

  // Waits until every queued beat is sent and every result has come back,
  // then lets the pipeline settle. Sampling at the falling edge keeps this
  // clear of the updates made at the rising edge.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_hits.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // One register write. Only called while the block is idle, so the local
  // copy of the trigger can follow at once.
  task automatic write_trigger(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx <= REG_TRIGGER_Z) begin
      trig_model[idx] = TRIG_W'(val);
    end
  endtask

  task automatic set_triggers(input int tx, input int ty, input int tz);
    write_trigger(REG_TRIGGER_X, tx);
    write_trigger(REG_TRIGGER_Y, ty);
    write_trigger(REG_TRIGGER_Z, tz);
  endtask

  // Input driver. The sender works in bursts of random length separated by
  // random gaps; a gap of zero gives stretches of back-to-back beats. A beat
  // that is offered stays put until the block takes it, and every accepted
  // beat is run through the predictor right at the accepting edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_hits.push_back(predict_hits(in_data));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each result beat is matched against the oldest
  // expectation, field by field. The ready pattern steps through four moods
  // in turn as rx_tick counts up: always ready, coin toss, one cycle in four,
  // and mostly ready, so stalls land on every part of the block's work.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_tick   <= '0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_hits.size() == 0) begin
          note_error($sformatf("result beat %p with nothing expected", out_data));
        end else begin
          oldest = expected_hits.pop_front();
          if (out_data.hit_x !== oldest.hit_x) begin
            note_error($sformatf("hit_x got %b want %b", out_data.hit_x, oldest.hit_x));
          end
          if (out_data.hit_y !== oldest.hit_y) begin
            note_error($sformatf("hit_y got %b want %b", out_data.hit_y, oldest.hit_y));
          end
          if (out_data.hit_z !== oldest.hit_z) begin
            note_error($sformatf("hit_z got %b want %b", out_data.hit_z, oldest.hit_z));
          end
          if (out_data.calibrating !== oldest.calibrating) begin
            note_error($sformatf("calibrating got %b want %b",
                                 out_data.calibrating, oldest.calibrating));
          end
        end
      end
      rx_tick <= rx_tick + 1'b1;
      case (rx_tick[7:6])
        2'd0:    out_ready <= 1'b1;
        2'd1:    out_ready <= ($urandom_range(0, 1) == 1);
        2'd2:    out_ready <= (rx_tick[1:0] == 2'd0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Stimulus sequence. Each phase fills the queue, then waits for the block
  // to drain before the next register change, which also makes the sender
  // pause until every expected result has come back.
  initial begin
    int tx, ty, tz;
    int i;
    in_t item;

    // Calibration beats: all zeros, full scale and alternating bit patterns
    // first, then noise around a distinct level per axis so the three
    // baselines differ.
    for (i = 0; i < CALIB_SAMPLES; i++) begin
      case (i)
        0:       item = '{sample_x: '0, sample_y: '0, sample_z: '0};
        1:       item = '{sample_x: '1, sample_y: '1, sample_z: '1};
        2:       item = '{sample_x: 12'hAAA, sample_y: 12'h555, sample_z: 12'hAAA};
        3:       item = '{sample_x: 12'h555, sample_y: 12'hAAA, sample_z: 12'h555};
        default: begin
          item.sample_x = clip_sample(300 + int'($urandom_range(0, 128)) - 64);
          item.sample_y = clip_sample(2000 + int'($urandom_range(0, 128)) - 64);
          item.sample_z = clip_sample(3000 + int'($urandom_range(0, 128)) - 64);
        end
      endcase
      pending_items.push_back(item);
      // Halfway through, stop and write registers while calibration is
      // still running: the new y trigger must hold once detection starts,
      // and the write to the unused index must change nothing.
      if (i == CALIB_SAMPLES / 2) begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();
        write_trigger(REG_TRIGGER_Y, 1000);
        write_trigger(REG_UNUSED, 12'h123);
      end
    end
    wait_idle();

    // Directed beats around the thresholds, with the baselines now known.
    tx = int'(trig_model[0]);
    ty = int'(trig_model[1]);
    tz = int'(trig_model[2]);
    push_offsets(0, 0, 0);
    // A distance equal to the trigger is not a hit.
    push_offsets(tx, ty, tz);
    push_offsets(tx + 1, 0, 0);
    // x is disarmed now and stays quiet while y and z fire.
    push_offsets(tx + 1, ty + 1, tz + 1);
    // Sitting exactly at half the trigger does not re-arm.
    push_offsets(tx / 2, ty / 2, tz / 2);
    push_offsets(tx / 2 - 1, ty / 2 - 1, tz / 2 - 1);
    // Zero samples are clamped up to the baseline.
    push_offsets(-SAMPLE_MAX, -SAMPLE_MAX, -SAMPLE_MAX);
    push_offsets(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    push_offsets(0, 0, 0);
    wait_idle();

    // A zero trigger fires on any nonzero distance and never re-arms.
    set_triggers(0, 0, 0);
    write_trigger(REG_UNUSED, 12'h5A5);
    push_offsets(0, 0, 0);
    push_offsets(1, 1, 1);
    push_offsets(0, 0, 0);
    push_offsets(1, 1, 1);
    wait_idle();

    // A full-scale trigger re-arms on a quiet sample but can never fire.
    set_triggers(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    push_offsets(0, 0, 0);
    push_offsets(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    push_offsets(-1, -1, -1);
    wait_idle();

    // Random phases, each with its own trigger settings.
    for (i = 0; i < 5; i++) begin
      case (i)
        0: set_triggers($urandom_range(100, 800), $urandom_range(100, 800),
                        $urandom_range(100, 800));
        1: set_triggers(0, SAMPLE_MAX, $urandom_range(0, SAMPLE_MAX));
        2: set_triggers($urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 3));
        3: set_triggers($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
                        $urandom_range(0, SAMPLE_MAX));
        default: set_triggers(TRIG_RESET, TRIG_RESET, TRIG_RESET);
      endcase
      push_random(RANDOM_BEATS);
      wait_idle();
    end

    // Extra quiet time so a stray late result beat is still caught.
    repeat (10) @(negedge clk);
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Verification failed");
    $finish;
  end

endmodule
